// ----- rtl/core/agsp_pkg.sv -----
`timescale 1ns / 1ps
package agsp_pkg;

	localparam int MAX_AREAS      = 64;
	localparam int MAX_LINKS      = 256;
	localparam int NUM_DIRECTIONS = 4;
	localparam int QUEUE_DEPTH    = 256;

	localparam int AREA_W  = $clog2(MAX_AREAS);
	localparam int LINK_W  = $clog2(MAX_LINKS);
	localparam int DIR_W   = $clog2(NUM_DIRECTIONS);
	localparam int SLOT_W  = AREA_W + DIR_W;
	localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
	localparam int DIST_W  = 24;
	localparam int CFG_W   = 9;

	localparam logic [DIST_W-1:0] UNREACHED = '1;
	localparam logic [DIST_W-1:0] DIST_MAX  = {{(DIST_W-1){1'b1}}, 1'b0};

	localparam logic [2:0] CMD_SLOT  = 3'd0;
	localparam logic [2:0] CMD_WALK  = 3'd1;
	localparam logic [2:0] CMD_LINK  = 3'd2;
	localparam logic [2:0] CMD_RUN   = 3'd3;
	localparam logic [2:0] CMD_QUERY = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD      = 2'd1;
	localparam logic [1:0] ST_CORRUPT  = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	localparam logic CFG_AREA_COUNT = 1'b0;
	localparam logic CFG_LINK_TOTAL = 1'b1;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [5:0]  area;
		logic [1:0]  direction;
		logic [7:0]  slot_start;
		logic [8:0]  slot_count;
		logic        walkable;
		logic [7:0]  link_entry;
		logic [5:0]  link_target;
		logic [15:0] link_scale;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic        reachable;
		logic [23:0] distance;
		logic        has_from;
		logic [7:0]  from_link;
	} out_item_t;

endpackage

// ----- rtl/core/agsp_engine.sv -----
`timescale 1ns / 1ps
module agsp_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  agsp_pkg::in_item_t   item,
	input  logic                 item_go,
	input  logic [6:0]           area_count,
	input  logic [8:0]           link_total,
	output logic                 busy,
	output logic                 res_valid,
	output agsp_pkg::out_item_t  res
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_CLEAR  = 10'b0000000010,
		S_POP    = 10'b0000000100,
		S_POPW   = 10'b0000001000,
		S_SLOT   = 10'b0000010000,
		S_SLOTW  = 10'b0000100000,
		S_LINK   = 10'b0001000000,
		S_LINKW  = 10'b0010000000,
		S_RELAX  = 10'b0100000000,
		S_QUERY  = 10'b1000000000
	} state_t;

	state_t state_q;

	// memories
	logic [16:0] slot_mem [agsp_pkg::MAX_AREAS*agsp_pkg::NUM_DIRECTIONS];
	logic [21:0] link_mem [agsp_pkg::MAX_LINKS];
	logic [5:0]  queue_mem [agsp_pkg::QUEUE_DEPTH];
	logic [23:0] dist_mem [agsp_pkg::MAX_AREAS];
	logic [8:0]  from_mem [agsp_pkg::MAX_AREAS];
	logic [agsp_pkg::MAX_AREAS-1:0] walk_q, seen_q;

	logic [16:0] slot_rd_q;
	logic [21:0] link_rd_q;
	logic [5:0]  queue_rd_q;
	logic [23:0] dist_rd_q;
	logic [8:0]  from_rd_q;

	logic [agsp_pkg::QPTR_W-1:0] head_q, tail_q;
	logic [agsp_pkg::QPTR_W:0]   fill_q;
	logic [5:0]  cur_q, clr_q;
	logic [23:0] cur_dist_q;
	logic [agsp_pkg::DIR_W:0] dir_q;
	logic [8:0]  j_q, k_q;
	logic        corrupt_q, overflow_q, ran_q;
	logic [5:0]  qarea_q;

	// read address muxes
	logic [5:0]  dist_ra;
	logic [7:0]  slot_ra;
	logic [5:0]  tgt;
	logic [6:0]  na;
	logic [8:0]  nl;
	logic [17:0] cost;
	logic [24:0] nd_raw;
	logic [23:0] nd;
	logic [9:0]  kend;
	logic        pop_ok, dwe;
	logic [5:0]  dwa;
	logic [23:0] dwd;
	logic [8:0]  fwd;

	assign na = (area_count > 7'(agsp_pkg::MAX_AREAS)) ? 7'(agsp_pkg::MAX_AREAS) : area_count;
	assign nl = (link_total > 9'(agsp_pkg::MAX_LINKS)) ? 9'(agsp_pkg::MAX_LINKS) : link_total;
	assign tgt = link_rd_q[21:16];
	assign cost = {link_rd_q[15:0], 2'b00};
	assign nd_raw = {1'b0, cur_dist_q} + 25'(cost);
	assign nd = (nd_raw > 25'(agsp_pkg::DIST_MAX)) ? agsp_pkg::DIST_MAX : nd_raw[23:0];
	assign kend = {2'b00, slot_rd_q[7:0]} + {1'b0, slot_rd_q[16:8]};
	assign slot_ra = {cur_q, dir_q[agsp_pkg::DIR_W-1:0]};
	assign dist_ra = (state_q == S_IDLE) ? item.area : (state_q == S_POPW) ? queue_rd_q : tgt;
	assign pop_ok = fill_q != '0;

	// distance / from write port
	always_comb begin
		dwe = 1'b0;
		dwa = tgt;
		dwd = nd;
		fwd = {1'b1, j_q[7:0]};
		if (state_q == S_CLEAR) begin
			dwe = 1'b1;
			dwa = clr_q;
			dwd = (clr_q == qarea_q) ? '0 : agsp_pkg::UNREACHED;
			fwd = '0;
		end else if (state_q == S_RELAX && !seen_q[tgt] && (7'(tgt) < na) && walk_q[tgt]
				&& dist_rd_q > nd) begin
			dwe = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (item_go && item.cmd == agsp_pkg::CMD_SLOT)
			slot_mem[{item.area, item.direction}] <= {item.slot_count, item.slot_start};
		if (item_go && item.cmd == agsp_pkg::CMD_LINK)
			link_mem[item.link_entry] <= {item.link_target, item.link_scale};
		if (dwe) begin
			dist_mem[dwa] <= dwd;
			from_mem[dwa] <= fwd;
		end
		slot_rd_q  <= slot_mem[slot_ra];
		link_rd_q  <= link_mem[j_q[7:0]];
		queue_rd_q <= queue_mem[head_q];
		dist_rd_q  <= dist_mem[dist_ra];
		from_rd_q  <= from_mem[dist_ra];
		if ((state_q == S_CLEAR && clr_q == '0) || (state_q == S_RELAX && dwe && !fill_q[agsp_pkg::QPTR_W]))
			queue_mem[tail_q] <= (state_q == S_CLEAR) ? qarea_q : tgt;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			walk_q <= '0;
			seen_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
			res_valid <= 1'b0;
			res <= '0;
			clr_q <= '0;
			cur_q <= '0;
			cur_dist_q <= '0;
			dir_q <= '0;
			j_q <= '0;
			k_q <= '0;
			corrupt_q <= 1'b0;
			overflow_q <= 1'b0;
			ran_q <= 1'b0;
			qarea_q <= '0;
		end else begin
			res_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (item_go) begin
						case (item.cmd)
							agsp_pkg::CMD_WALK: walk_q[item.area] <= item.walkable;
							agsp_pkg::CMD_RUN: begin
								if (7'(item.area) >= na) begin
									res_valid <= 1'b1;
									res <= '{kind: 1'b0, status: agsp_pkg::ST_BAD, default: '0};
								end else begin
									state_q <= S_CLEAR;
									qarea_q <= item.area;
									ran_q <= 1'b1;
									clr_q <= '0;
									head_q <= '0;
									tail_q <= '0;
									fill_q <= '0;
									corrupt_q <= 1'b0;
									overflow_q <= 1'b0;
								end
							end
							agsp_pkg::CMD_QUERY: begin
								state_q <= S_QUERY;
								qarea_q <= item.area;
							end
							default: ;
						endcase
					end
				end
				S_QUERY: begin
					// distance and from memories are unknown until the first run clears them
					res_valid <= 1'b1;
					res.kind <= 1'b1;
					res.status <= agsp_pkg::ST_OK;
					if (ran_q && 7'(qarea_q) < na && dist_rd_q != agsp_pkg::UNREACHED) begin
						res.reachable <= 1'b1;
						res.distance <= dist_rd_q;
					end else begin
						res.reachable <= 1'b0;
						res.distance <= '0;
					end
					if (ran_q && 7'(qarea_q) < na && from_rd_q[8]) begin
						res.has_from <= 1'b1;
						res.from_link <= from_rd_q[7:0];
					end else begin
						res.has_from <= 1'b0;
						res.from_link <= '0;
					end
					state_q <= S_IDLE;
				end
				S_CLEAR: begin
					if (clr_q == '0) begin
						tail_q <= 8'd1;
						fill_q <= 9'd1;
					end
					clr_q <= clr_q + 6'd1;
					if (clr_q == 6'(agsp_pkg::MAX_AREAS-1))
						state_q <= S_POP;
				end
				S_POP: begin
					if (pop_ok) begin
						head_q <= head_q + 8'd1;
						fill_q <= fill_q - 9'd1;
						state_q <= S_POPW;
					end else begin
						res_valid <= 1'b1;
						res <= '{kind: 1'b0,
							status: overflow_q ? agsp_pkg::ST_OVERFLOW
								: corrupt_q ? agsp_pkg::ST_CORRUPT : agsp_pkg::ST_OK,
							default: '0};
						state_q <= S_IDLE;
					end
				end
				S_POPW: begin
					// queue entry in queue_rd_q, distance read issued
					cur_q <= queue_rd_q;
					dir_q <= '0;
					seen_q <= '0;
					state_q <= S_SLOT;
				end
				S_SLOT: begin
					// popped area distance is only on the read port right after the pop
					if (dir_q == '0)
						cur_dist_q <= dist_rd_q;
					if (dir_q == (agsp_pkg::DIR_W+1)'(agsp_pkg::NUM_DIRECTIONS))
						state_q <= S_POP;
					else
						state_q <= S_SLOTW;
				end
				S_SLOTW: begin
					if (kend > {1'b0, nl}) begin
						corrupt_q <= 1'b1;
						state_q <= S_POP;
					end else begin
						j_q <= {1'b0, slot_rd_q[7:0]};
						k_q <= kend[8:0];
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					if (j_q >= k_q) begin
						dir_q <= dir_q + (agsp_pkg::DIR_W+1)'(1);
						state_q <= S_SLOT;
					end else
						state_q <= S_LINKW;
				end
				S_LINKW: state_q <= S_RELAX;
				S_RELAX: begin
					seen_q[tgt] <= 1'b1;
					if (dwe) begin
						if (fill_q[agsp_pkg::QPTR_W])
							overflow_q <= 1'b1;
						else begin
							tail_q <= tail_q + 8'd1;
							fill_q <= fill_q + 9'd1;
						end
					end
					j_q <= j_q + 9'd1;
					state_q <= S_LINK;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;

endmodule

// ----- rtl/core/area_graph_shortest_path.sv -----
`timescale 1ns / 1ps
// channel | direction | handshake
// in      | input     | in_valid / in_stall
// out     | output    | out_valid / out_stall
// cfg     | input     | cfg_we, cfg_index, cfg_data
// loads write on acceptance; a query result goes via S_QUERY, the result and the output register.
// a run clears all 64 area entries, then per popped area reads the slot of each direction and
// relaxes each link, and ends on a pop of the empty queue, all through the single sequencer.
// reset clears control state and the walkable map; queries before the first run answer unreached.
// in_stall is high while a run or query is in flight or a result is pending or held at the output.
module area_graph_shortest_path (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  agsp_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output agsp_pkg::out_item_t  out_item,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [agsp_pkg::CFG_W-1:0] cfg_data
);

	logic [6:0] area_count_q;
	logic [8:0] link_total_q;
	logic busy, res_valid, go;
	agsp_pkg::out_item_t res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_count_q <= 7'd1;
			link_total_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == agsp_pkg::CFG_AREA_COUNT)
				area_count_q <= cfg_data[6:0];
			else
				link_total_q <= cfg_data;
		end
	end

	assign in_stall = busy || res_valid || out_valid;
	assign go = in_valid && !in_stall;

	agsp_engine u_engine (
		.clk(clk), .arst_n(arst_n), .item(in_item), .item_go(go),
		.area_count(area_count_q), .link_total(link_total_q),
		.busy(busy), .res_valid(res_valid), .res(res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			out_item <= '0;
		end else if (res_valid) begin
			out_valid <= 1'b1;
			out_item <= res;
		end else if (!out_stall)
			out_valid <= 1'b0;
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall) else $error("accept while busy");
	a_res_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> out_valid) else $error("result lost");
	a_no_res_on_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !res_valid) else $error("result overrun");
`endif

endmodule

// ----- bench/area_graph_shortest_path_test.sv -----
`timescale 1ns / 1ps
module area_graph_shortest_path_test;

	localparam int WATCHDOG_LIMIT = 500000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	agsp_pkg::in_item_t in_item;
	logic out_valid;
	logic out_stall;
	agsp_pkg::out_item_t out_item;
	logic cfg_we;
	logic cfg_index;
	logic [agsp_pkg::CFG_W-1:0] cfg_data;

	area_graph_shortest_path u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow copy of the block state
	logic [6:0] area_cnt_m;
	logic [8:0] link_tot_m;
	logic [7:0] slot_first_m [agsp_pkg::MAX_AREAS*agsp_pkg::NUM_DIRECTIONS];
	logic [8:0] slot_len_m [agsp_pkg::MAX_AREAS*agsp_pkg::NUM_DIRECTIONS];
	logic walk_m [agsp_pkg::MAX_AREAS];
	logic [5:0] link_tgt_m [agsp_pkg::MAX_LINKS];
	logic [15:0] link_scale_m [agsp_pkg::MAX_LINKS];
	logic [23:0] dist_m [agsp_pkg::MAX_AREAS];
	logic from_ok_m [agsp_pkg::MAX_AREAS];
	logic [7:0] from_link_m [agsp_pkg::MAX_AREAS];

	agsp_pkg::out_item_t expected_results[$];
	int send_idle;
	int recv_idle;
	int mismatches;
	int quiet_cycles;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver stall
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	// shortest path run on the shadow state, returns the run status
	function automatic logic [1:0] predict_run(int start);
		int na, nl, cur, j, k, tgt, d;
		int pend [agsp_pkg::QUEUE_DEPTH];
		int p_head, p_tail, p_fill;
		bit corrupt, overflow;
		bit seen[agsp_pkg::MAX_AREAS];
		longint nd;
		na = area_cnt_m < agsp_pkg::MAX_AREAS ? area_cnt_m : agsp_pkg::MAX_AREAS;
		nl = link_tot_m < agsp_pkg::MAX_LINKS ? link_tot_m : agsp_pkg::MAX_LINKS;
		corrupt = 0;
		overflow = 0;
		if (start >= na) return agsp_pkg::ST_BAD;
		for (int i = 0; i < agsp_pkg::MAX_AREAS; i++) begin
			dist_m[i] = agsp_pkg::UNREACHED;
			from_ok_m[i] = 0;
			from_link_m[i] = 0;
		end
		dist_m[start] = 0;
		pend[0] = start;
		p_head = 0;
		p_tail = 1;
		p_fill = 1;
		while (p_fill > 0) begin
			cur = pend[p_head];
			p_head = (p_head + 1) % agsp_pkg::QUEUE_DEPTH;
			p_fill--;
			for (int i = 0; i < agsp_pkg::MAX_AREAS; i++) seen[i] = 0;
			for (d = 0; d < agsp_pkg::NUM_DIRECTIONS; d++) begin
				j = slot_first_m[cur*agsp_pkg::NUM_DIRECTIONS+d];
				k = j + slot_len_m[cur*agsp_pkg::NUM_DIRECTIONS+d];
				if (k > nl) begin
					corrupt = 1;
					break;
				end
				for (; j < k; j++) begin
					tgt = link_tgt_m[j];
					if (seen[tgt]) continue;
					seen[tgt] = 1;
					if (tgt >= na || !walk_m[tgt]) continue;
					nd = longint'(dist_m[cur]) + longint'(link_scale_m[j]) * 4;
					if (nd > agsp_pkg::DIST_MAX) nd = agsp_pkg::DIST_MAX;
					if (dist_m[tgt] > nd) begin
						dist_m[tgt] = nd[23:0];
						from_ok_m[tgt] = 1;
						from_link_m[tgt] = j[7:0];
						if (p_fill >= agsp_pkg::QUEUE_DEPTH) overflow = 1;
						else begin
							pend[p_tail] = tgt;
							p_tail = (p_tail + 1) % agsp_pkg::QUEUE_DEPTH;
							p_fill++;
						end
					end
				end
			end
		end
		if (overflow) return agsp_pkg::ST_OVERFLOW;
		return corrupt ? agsp_pkg::ST_CORRUPT : agsp_pkg::ST_OK;
	endfunction

	// apply one accepted transaction to the shadow state
	task automatic apply_item(agsp_pkg::in_item_t it);
		agsp_pkg::out_item_t r;
		int na;
		r = '0;
		na = area_cnt_m < agsp_pkg::MAX_AREAS ? area_cnt_m : agsp_pkg::MAX_AREAS;
		case (it.cmd)
			agsp_pkg::CMD_SLOT: begin
				slot_first_m[it.area*agsp_pkg::NUM_DIRECTIONS+it.direction] = it.slot_start;
				slot_len_m[it.area*agsp_pkg::NUM_DIRECTIONS+it.direction] = it.slot_count;
			end
			agsp_pkg::CMD_WALK: walk_m[it.area] = it.walkable;
			agsp_pkg::CMD_LINK: begin
				link_tgt_m[it.link_entry] = it.link_target;
				link_scale_m[it.link_entry] = it.link_scale;
			end
			agsp_pkg::CMD_RUN: begin
				r.kind = 1'b0;
				r.status = predict_run(it.area);
				expected_results.insert(expected_results.size(), r);
			end
			agsp_pkg::CMD_QUERY: begin
				r.kind = 1'b1;
				if (it.area < na && dist_m[it.area] != agsp_pkg::UNREACHED) begin
					r.reachable = 1'b1;
					r.distance = dist_m[it.area];
				end
				if (it.area < na && from_ok_m[it.area]) begin
					r.has_from = 1'b1;
					r.from_link = from_link_m[it.area];
				end
				expected_results.insert(expected_results.size(), r);
			end
			default: ;
		endcase
	endtask

	// send one transaction, honoring random sender gaps
	task automatic send_item(agsp_pkg::in_item_t it);
		while ($urandom_range(99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_item = it;
		do @(posedge clk); while (in_stall);
		apply_item(it);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// wait until all results are back and the block has gone quiet
	task automatic drain();
		while (expected_results.size() > 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [agsp_pkg::CFG_W-1:0] value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == agsp_pkg::CFG_AREA_COUNT) area_cnt_m = value[6:0];
		else link_tot_m = value;
	endtask

	function automatic agsp_pkg::in_item_t make_slot(int a, int d, int s, int c);
		agsp_pkg::in_item_t it;
		it = '0;
		it.cmd = agsp_pkg::CMD_SLOT;
		it.area = 6'(a);
		it.direction = 2'(d);
		it.slot_start = 8'(s);
		it.slot_count = 9'(c);
		return it;
	endfunction

	function automatic agsp_pkg::in_item_t make_link(int idx, int tgt, int scale);
		agsp_pkg::in_item_t it;
		it = '0;
		it.cmd = agsp_pkg::CMD_LINK;
		it.link_entry = 8'(idx);
		it.link_target = 6'(tgt);
		it.link_scale = 16'(scale);
		return it;
	endfunction

	function automatic agsp_pkg::in_item_t make_cmd(logic [2:0] cmd, int a, bit w);
		agsp_pkg::in_item_t it;
		it = '0;
		it.cmd = cmd;
		it.area = 6'(a);
		it.walkable = w;
		return it;
	endfunction

	// fill every slot, link entry and walkable flag so no run reads an unwritten entry
	task automatic test_store_fill();
		write_reg(agsp_pkg::CFG_AREA_COUNT, 9'd64);
		write_reg(agsp_pkg::CFG_LINK_TOTAL, 9'd256);
		for (int i = 0; i < agsp_pkg::MAX_LINKS; i++)
			send_item(make_link(i, $urandom_range(63), $urandom_range(65535)));
		for (int i = 0; i < agsp_pkg::MAX_AREAS*agsp_pkg::NUM_DIRECTIONS; i++)
			send_item(make_slot(i / 4, i % 4, 0, 0));
		for (int i = 0; i < agsp_pkg::MAX_AREAS; i++)
			send_item(make_cmd(agsp_pkg::CMD_WALK, i, 1'($urandom_range(1))));
	endtask

	// small hand-built graph covering the named corner cases
	task automatic test_directed();
		// unreached before any run, also for the last configured area
		send_item(make_cmd(agsp_pkg::CMD_QUERY, 3, 0));
		send_item(make_cmd(agsp_pkg::CMD_QUERY, 63, 0));
		send_item(make_link(0, 1, 0));
		send_item(make_link(1, 2, 65535));
		send_item(make_link(2, 1, 5));
		send_item(make_link(3, 40, 7));
		send_item(make_link(4, 3, 9));
		send_item(make_slot(0, 0, 0, 2));
		send_item(make_slot(0, 3, 2, 3));
		send_item(make_cmd(agsp_pkg::CMD_WALK, 1, 1));
		send_item(make_cmd(agsp_pkg::CMD_WALK, 2, 1));
		send_item(make_cmd(agsp_pkg::CMD_WALK, 3, 0));
		send_item(make_cmd(agsp_pkg::CMD_WALK, 40, 1));
		send_item(make_cmd(3'd7, 0, 1));
		drain();
		write_reg(agsp_pkg::CFG_AREA_COUNT, 9'd5);
		write_reg(agsp_pkg::CFG_LINK_TOTAL, 9'd5);
		send_item(make_cmd(agsp_pkg::CMD_RUN, 0, 0));
		send_item(make_cmd(agsp_pkg::CMD_QUERY, 1, 0));
		send_item(make_cmd(agsp_pkg::CMD_QUERY, 2, 0));
		send_item(make_cmd(agsp_pkg::CMD_QUERY, 0, 0));
		send_item(make_cmd(agsp_pkg::CMD_RUN, 5, 0));
		// range past the link total
		send_item(make_slot(1, 2, 255, 9'd511));
		send_item(make_cmd(agsp_pkg::CMD_RUN, 0, 0));
		send_item(make_cmd(agsp_pkg::CMD_QUERY, 4, 0));
		send_item(make_slot(1, 2, 0, 0));
		drain();
		write_reg(agsp_pkg::CFG_AREA_COUNT, 9'd0);
		send_item(make_cmd(agsp_pkg::CMD_RUN, 0, 0));
		send_item(make_cmd(agsp_pkg::CMD_QUERY, 0, 0));
		drain();
	endtask

	// dense graph where every area links to all higher areas
	task automatic test_queue_overflow();
		write_reg(agsp_pkg::CFG_AREA_COUNT, 9'd32);
		write_reg(agsp_pkg::CFG_LINK_TOTAL, 9'd256);
		for (int j = 0; j < 32; j++) begin
			send_item(make_link(j, j, 1));
			send_item(make_link(64 + j, j, 1000 * j));
			send_item(make_cmd(agsp_pkg::CMD_WALK, j, 1));
		end
		send_item(make_slot(0, 0, 65, 31));
		for (int i = 1; i < 32; i++) send_item(make_slot(i, 0, i + 1, 31 - i));
		send_item(make_cmd(agsp_pkg::CMD_RUN, 0, 0));
		for (int i = 0; i < 32; i++) send_item(make_cmd(agsp_pkg::CMD_QUERY, i, 0));
		drain();
		for (int i = 0; i < 32; i++) send_item(make_slot(i, 0, 0, 0));
	endtask

	// random traffic, mostly small link ranges to keep runs short
	task automatic test_random(int count, int area_cfg, int link_cfg);
		agsp_pkg::in_item_t it;
		int na, pick;
		write_reg(agsp_pkg::CFG_AREA_COUNT, 9'(area_cfg));
		write_reg(agsp_pkg::CFG_LINK_TOTAL, 9'(link_cfg));
		na = area_cnt_m < agsp_pkg::MAX_AREAS ? area_cnt_m : agsp_pkg::MAX_AREAS;
		for (int n = 0; n < count; n++) begin
			it = agsp_pkg::in_item_t'($bits(agsp_pkg::in_item_t)'({$urandom, $urandom}));
			pick = $urandom_range(99);
			if (pick < 30) begin
				it.cmd = agsp_pkg::CMD_SLOT;
				if ($urandom_range(99) < 90) it.slot_count = 9'($urandom_range(3));
			end else if (pick < 45) it.cmd = agsp_pkg::CMD_WALK;
			else if (pick < 60) it.cmd = agsp_pkg::CMD_LINK;
			else if (pick < 70) begin
				it.cmd = agsp_pkg::CMD_RUN;
				if (na > 0 && $urandom_range(9) > 0) it.area = 6'($urandom_range(na - 1));
			end else if (pick < 95) it.cmd = agsp_pkg::CMD_QUERY;
			else it.cmd = 3'($urandom_range(5, 7));
			send_item(it);
		end
		drain();
	endtask

	// result checker
	always @(posedge clk) begin
		agsp_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", out_item);
			end else begin
				want = expected_results[0];
				expected_results.delete(0);
				if (out_item.kind !== want.kind || out_item.status !== want.status ||
					out_item.reachable !== want.reachable ||
					out_item.distance !== want.distance ||
					out_item.has_from !== want.has_from ||
					out_item.from_link !== want.from_link) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", want, out_item);
				end
			end
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = agsp_pkg::CFG_AREA_COUNT;
		cfg_data = '0;
		send_idle = 0;
		recv_idle = 0;
		mismatches = 0;
		quiet_cycles = 0;
		area_cnt_m = 7'd1;
		link_tot_m = 9'd0;
		for (int i = 0; i < agsp_pkg::MAX_AREAS; i++) begin
			walk_m[i] = 0;
			dist_m[i] = agsp_pkg::UNREACHED;
			from_ok_m[i] = 0;
			from_link_m[i] = 0;
		end
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		send_idle = 23;
		recv_idle = 61;
		test_store_fill();
		test_directed();
		test_queue_overflow();
		test_random(35, 64, 256);
		send_idle = 61;
		recv_idle = 23;
		test_random(35, 127, 511);
		send_idle = 0;
		recv_idle = 0;
		test_random(35, $urandom_range(1, 64), $urandom_range(0, 256));
		drain();
		if (mismatches == 0 && expected_results.size() == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule
